@@ design/assert_macros.svh @@
// Assertion macros shared by the cell update modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside of reset.
`define COLU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising clock edge, during reset as well.
`define COLU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ design/colu_pkg.sv @@
// Shared constants, types and helpers of the colored Life cell update block.
`default_nettype none

package colu_pkg;

  localparam int MaxColumns = 1024;
  localparam int MaxRows    = 1024;
  localparam int ColW       = $clog2(MaxColumns);
  localparam int RowW       = $clog2(MaxRows);
  localparam int CfgW       = 11;
  localparam int IdxW       = 2;
  localparam int ColorW     = 24;
  localparam int ResetSize  = 64;
  localparam int MinSize    = 3;

  // Register indexes of the configuration port.
  localparam logic [IdxW-1:0] RegColumns = IdxW'(0);
  localparam logic [IdxW-1:0] RegRows    = IdxW'(1);

  // First position along a row or a column whose transfer completes an interior neighborhood.
  localparam int FirstInner = 2;
  // Neighbor counts of the B3/S23 rule.
  localparam int SurviveMin = 2;
  localparam int BirthCount = 3;

  // A sum of three colors fits in SumW bits; multiplying by Recip and
  // shifting right by RecipShift gives the exact quotient by three.
  localparam int SumW       = ColorW + 2;
  localparam int RecipShift = SumW + 1;
  localparam logic [SumW-1:0] Recip = SumW'(((2 ** RecipShift) + 1) / 3);

  localparam int NbrCntW = 4;

  // Output queue depth; it also bounds the items in flight.
  localparam int OutDepth = 8;

  typedef struct packed {
    logic produce;  // the item completes an interior neighborhood
    logic last;     // final interior cell of the grid
  } colu_tag_t;

  function automatic int clamp_size(input int v, input int top);
    int r;
    r = v;
    if (v < MinSize) r = MinSize;
    else if (v > top) r = top;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/colu_ctrl.sv @@
// Grid size registers and raster position counters.
`default_nettype none
`include "assert_macros.svh"

module colu_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [colu_pkg::IdxW-1:0]    cfg_idx_i,
  input  wire logic [colu_pkg::CfgW-1:0]    cfg_wdata_i,
  input  wire logic                         accept_i,
  output logic      [colu_pkg::ColW-1:0]    addr_o,
  output colu_pkg::colu_tag_t               tag_o
);

  logic [colu_pkg::ColW-1:0] cols_m1_q, col_q, col_d;
  logic [colu_pkg::RowW-1:0] rows_m1_q, row_q, row_d;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (col_q == cols_m1_q) begin
      col_d = '0;
      row_d = (row_q == rows_m1_q) ? '0 : row_q + 1'b1;
    end else begin
      col_d = col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_m1_q <= colu_pkg::ColW'(colu_pkg::clamp_size(colu_pkg::ResetSize,
                                                        colu_pkg::MaxColumns) - 1);
      rows_m1_q <= colu_pkg::RowW'(colu_pkg::clamp_size(colu_pkg::ResetSize,
                                                        colu_pkg::MaxRows) - 1);
      col_q     <= '0;
      row_q     <= '0;
    end else if (cfg_we_i && (cfg_idx_i == colu_pkg::RegColumns)) begin
      cols_m1_q <= colu_pkg::ColW'(colu_pkg::clamp_size(int'(cfg_wdata_i),
                                                        colu_pkg::MaxColumns) - 1);
      col_q     <= '0;
      row_q     <= '0;
    end else if (cfg_we_i && (cfg_idx_i == colu_pkg::RegRows)) begin
      rows_m1_q <= colu_pkg::RowW'(colu_pkg::clamp_size(int'(cfg_wdata_i),
                                                        colu_pkg::MaxRows) - 1);
      col_q     <= '0;
      row_q     <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign addr_o        = col_q;
  assign tag_o.produce = (row_q >= colu_pkg::RowW'(colu_pkg::FirstInner)) &&
                         (col_q >= colu_pkg::ColW'(colu_pkg::FirstInner));
  assign tag_o.last    = (row_q == rows_m1_q) && (col_q == cols_m1_q);

  `COLU_ASSERT(a_pos_in_grid, (col_q <= cols_m1_q) && (row_q <= rows_m1_q), "position off the grid")

endmodule

`default_nettype wire

@@ design/colu_line_store.sv @@
// Two line stores with a read-modify-write pass per transfer.
`default_nettype none
`include "assert_macros.svh"

module colu_line_store (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         rd_en_i,
  input  wire logic [colu_pkg::ColW-1:0]    rd_addr_i,
  input  wire logic [colu_pkg::ColorW-1:0]  bottom_i,
  input  colu_pkg::colu_tag_t               tag_i,
  output logic                              v_o,
  output logic      [colu_pkg::ColorW-1:0]  top_o,
  output logic      [colu_pkg::ColorW-1:0]  mid_o,
  output logic      [colu_pkg::ColorW-1:0]  bottom_o,
  output colu_pkg::colu_tag_t               tag_o
);

  logic [colu_pkg::ColorW-1:0] upper_mem  [colu_pkg::MaxColumns];
  logic [colu_pkg::ColorW-1:0] middle_mem [colu_pkg::MaxColumns];

  logic                        wr_pend_q;
  logic [colu_pkg::ColW-1:0]   addr_q;
  logic [colu_pkg::ColorW-1:0] top_q, mid_q, bottom_q;
  colu_pkg::colu_tag_t         tag_q;

  // The rows shift down one store in the cycle after the read. Successive
  // transfers never touch the same column, so no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      top_q    <= upper_mem[rd_addr_i];
      mid_q    <= middle_mem[rd_addr_i];
      addr_q   <= rd_addr_i;
      bottom_q <= bottom_i;
      tag_q    <= tag_i;
    end
    if (wr_pend_q) begin
      upper_mem[addr_q]  <= mid_q;
      middle_mem[addr_q] <= bottom_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= rd_en_i;
    end
  end

  assign v_o      = wr_pend_q;
  assign top_o    = top_q;
  assign mid_o    = mid_q;
  assign bottom_o = bottom_q;
  assign tag_o    = tag_q;

  `COLU_ASSERT(a_rd_wr_apart, (rd_en_i && wr_pend_q) |-> (rd_addr_i != addr_q), "read hits the column being written back")

endmodule

`default_nettype wire

@@ design/colu_rule.sv @@
// Neighborhood window and pipelined B3/S23 rule with color averaging.
`default_nettype none

module colu_rule (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         v_i,
  input  wire logic [colu_pkg::ColorW-1:0]  top_i,
  input  wire logic [colu_pkg::ColorW-1:0]  mid_i,
  input  wire logic [colu_pkg::ColorW-1:0]  bottom_i,
  input  colu_pkg::colu_tag_t               tag_i,
  output logic                              v_o,
  output colu_pkg::colu_tag_t               tag_o,
  output logic      [colu_pkg::ColorW-1:0]  color_o
);

  localparam int PairW = colu_pkg::ColorW + 1;
  localparam int ProdW = 2 * colu_pkg::SumW;

  // Window rows top, middle, bottom; the newest column is at index 2.
  logic [colu_pkg::ColorW-1:0] win_q [9];
  logic                        wv_q, v2_q, v3_q, v4_q, v5_q;
  colu_pkg::colu_tag_t         wtag_q, tag2_q, tag3_q, tag4_q, tag5_q;

  logic [colu_pkg::ColorW-1:0]  nbr [8];
  logic [colu_pkg::NbrCntW-1:0] cnt_d;
  logic [colu_pkg::NbrCntW-1:0] cnt2_q, cnt3_q, cnt4_q, cnt5_q;
  logic [colu_pkg::ColorW-1:0]  ctr2_q, ctr3_q, ctr4_q, ctr5_q;
  logic [PairW-1:0]             pair_q [4];
  logic [colu_pkg::SumW-1:0]    half_q [2];
  logic [colu_pkg::SumW-1:0]    sum_q;
  logic [ProdW-1:0]             prod_q;

  always_comb begin
    cnt_d = '0;
    for (int j = 0; j < 8; j++) begin
      nbr[j] = (j < 4) ? win_q[j] : win_q[j + 1];
      cnt_d  = cnt_d + colu_pkg::NbrCntW'(nbr[j] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
      wv_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (v_i) begin
        for (int k = 0; k < 3; k++) begin
          win_q[k * 3 + 0] <= win_q[k * 3 + 1];
          win_q[k * 3 + 1] <= win_q[k * 3 + 2];
        end
        win_q[2] <= top_i;
        win_q[5] <= mid_i;
        win_q[8] <= bottom_i;
      end
      wv_q <= v_i;
      v2_q <= wv_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Payload stages; the sum of all eight neighbors equals the sum of the
  // live ones, and it only matters when exactly three are live.
  always_ff @(posedge clk_i) begin
    if (v_i) begin
      wtag_q <= tag_i;
    end
    tag2_q <= wtag_q;
    cnt2_q <= cnt_d;
    ctr2_q <= win_q[4];
    for (int p = 0; p < 4; p++) begin
      pair_q[p] <= PairW'(nbr[2 * p]) + PairW'(nbr[2 * p + 1]);
    end

    tag3_q    <= tag2_q;
    cnt3_q    <= cnt2_q;
    ctr3_q    <= ctr2_q;
    half_q[0] <= colu_pkg::SumW'(pair_q[0]) + colu_pkg::SumW'(pair_q[1]);
    half_q[1] <= colu_pkg::SumW'(pair_q[2]) + colu_pkg::SumW'(pair_q[3]);

    tag4_q <= tag3_q;
    cnt4_q <= cnt3_q;
    ctr4_q <= ctr3_q;
    sum_q  <= half_q[0] + half_q[1];

    tag5_q <= tag4_q;
    cnt5_q <= cnt4_q;
    ctr5_q <= ctr4_q;
    prod_q <= ProdW'(sum_q) * ProdW'(colu_pkg::Recip);
  end

  always_comb begin
    color_o = '0;
    if (ctr5_q != '0) begin
      if ((cnt5_q == colu_pkg::NbrCntW'(colu_pkg::SurviveMin)) ||
          (cnt5_q == colu_pkg::NbrCntW'(colu_pkg::BirthCount))) begin
        color_o = ctr5_q;
      end
    end else if (cnt5_q == colu_pkg::NbrCntW'(colu_pkg::BirthCount)) begin
      color_o = prod_q[colu_pkg::RecipShift +: colu_pkg::ColorW];
    end
  end

  assign v_o   = v5_q;
  assign tag_o = tag5_q;

endmodule

`default_nettype wire

@@ design/colu_out_fifo.sv @@
// Output queue with a credit count that bounds the items in flight.
`default_nettype none
`include "assert_macros.svh"

module colu_out_fifo (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         accept_i,
  input  wire logic                         push_i,
  input  wire logic                         drop_i,
  input  wire logic [colu_pkg::ColorW-1:0]  color_i,
  input  wire logic                         last_i,
  output logic                              ready_o,
  output logic                              m_valid_o,
  input  wire logic                         m_ready_i,
  output logic      [colu_pkg::ColorW-1:0]  m_color_o,
  output logic                              m_last_o
);

  localparam int PtrW = $clog2(colu_pkg::OutDepth);
  localparam int CntW = $clog2(colu_pkg::OutDepth + 1);

  logic [colu_pkg::ColorW:0] entry_q [colu_pkg::OutDepth];
  logic [PtrW-1:0]           wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]           count_q, inflight_q;
  logic                      pop;

  assign pop = m_valid_o && m_ready_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= {last_i, color_i};
    end
  end

  // Every accepted transfer holds one credit until its result leaves the
  // queue, or until it leaves the pipeline without a result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      count_q    <= '0;
      inflight_q <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)    rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q    <= count_q + CntW'(push_i) - CntW'(pop);
      inflight_q <= inflight_q + CntW'(accept_i) - CntW'(pop) - CntW'(drop_i);
    end
  end

  assign ready_o   = (inflight_q != CntW'(colu_pkg::OutDepth));
  assign m_valid_o = (count_q != '0);
  assign m_color_o = entry_q[rd_ptr_q][colu_pkg::ColorW-1:0];
  assign m_last_o  = entry_q[rd_ptr_q][colu_pkg::ColorW];

  `COLU_ASSERT(a_queue_within_credit, count_q <= inflight_q, "queue holds more than the credits taken")
  `COLU_ASSERT(a_no_overflow, push_i |-> (count_q != CntW'(colu_pkg::OutDepth)), "push into a full queue")

endmodule

`default_nettype wire

@@ design/color_life_cell_update.sv @@
// Throughput: one cell per cycle while the in-flight bound keeps s_axis_tready
// high; the two line stores are read and written back once per cell, and an
// 8-entry output queue absorbs sink stalls.
// Reset: sizes return to 64 x 64, positions to the frame start, window and
// output queue are cleared; the line stores are not cleared and need no pass.
`default_nettype none

module color_life_cell_update (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [23:0]                  s_axis_tdata,   // [23:0] cell_color
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic      [23:0]                  m_axis_tdata,   // [23:0] new_color
  output logic                              m_axis_tlast,
  input  wire logic                         cfg_we_i,
  input  wire logic [colu_pkg::IdxW-1:0]    cfg_idx_i,
  input  wire logic [colu_pkg::CfgW-1:0]    cfg_wdata_i
);

  logic                        accept;
  logic [colu_pkg::ColW-1:0]   addr;
  colu_pkg::colu_tag_t         pos_tag, ls_tag, rule_tag;
  logic                        ls_v, rule_v;
  logic [colu_pkg::ColorW-1:0] ls_top, ls_mid, ls_bottom, rule_color;

  assign accept = s_axis_tvalid && s_axis_tready;

  colu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .addr_o      (addr),
    .tag_o       (pos_tag)
  );

  colu_line_store u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (addr),
    .bottom_i  (s_axis_tdata[colu_pkg::ColorW-1:0]),
    .tag_i     (pos_tag),
    .v_o       (ls_v),
    .top_o     (ls_top),
    .mid_o     (ls_mid),
    .bottom_o  (ls_bottom),
    .tag_o     (ls_tag)
  );

  colu_rule u_rule (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .v_i      (ls_v),
    .top_i    (ls_top),
    .mid_i    (ls_mid),
    .bottom_i (ls_bottom),
    .tag_i    (ls_tag),
    .v_o      (rule_v),
    .tag_o    (rule_tag),
    .color_o  (rule_color)
  );

  colu_out_fifo u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .push_i    (rule_v && rule_tag.produce),
    .drop_i    (rule_v && !rule_tag.produce),
    .color_i   (rule_color),
    .last_i    (rule_tag.last),
    .ready_o   (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_color_o (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ tb/color_life_cell_update_tb.sv @@
// Self-checking testbench for the colored Life cell update block.
`timescale 1ns / 100ps

module color_life_cell_update_tb;

  localparam int CycleLimit   = 1000000;
  localparam int SettleCycles = 16;
  localparam int MaxReports   = 40;
  localparam int SurviveLow   = 2;
  localparam int BirthNbrs    = 3;
  localparam int SmallestSize = 3;
  localparam int WideCells    = 48;
  localparam int TallRows     = 16;
  localparam int RandomItems  = 400;

  // Indexes that hold no register; writes there must leave the frame alone.
  localparam logic [colu_pkg::IdxW-1:0] RegSpareA = colu_pkg::IdxW'(2);
  localparam logic [colu_pkg::IdxW-1:0] RegSpareB = colu_pkg::IdxW'(3);

  typedef struct packed {
    logic [colu_pkg::ColorW-1:0] color;
    logic                        last;
  } life_result_t;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [23:0]                 s_axis_tdata  = '0;  // [23:0] cell_color
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [23:0]                 m_axis_tdata;        // [23:0] new_color
  logic                        m_axis_tlast;
  logic                        cfg_we_i      = 1'b0;
  logic [colu_pkg::IdxW-1:0]   cfg_idx_i     = '0;
  logic [colu_pkg::CfgW-1:0]   cfg_wdata_i   = '0;

  color_life_cell_update dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Predictor state of the block.
  logic [colu_pkg::CfgW-1:0]   width_setting;
  logic [colu_pkg::CfgW-1:0]   height_setting;
  logic [colu_pkg::ColorW-1:0] row_above_above [colu_pkg::MaxColumns];
  logic [colu_pkg::ColorW-1:0] row_above [colu_pkg::MaxColumns];
  logic [colu_pkg::ColorW-1:0] neighborhood [9];
  int                          next_col;
  int                          next_row;

  life_result_t      colors_due[$];

  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int cycle_count     = 0;
  int mismatch_count  = 0;
  int cells_sent      = 0;
  int results_checked = 0;
  int size_settings   = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic report_mismatch(input string what,
                                 input logic [colu_pkg::ColorW-1:0] want,
                                 input logic [colu_pkg::ColorW-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MaxReports)
      $display("mismatch at cycle %0d: %s expected %h, got %h", cycle_count, what, want, got);
  endtask

  always @(posedge clk_i) begin
    life_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (colors_due.size() == 0) begin
        report_mismatch("unexpected result, new_color", '0, m_axis_tdata);
      end else begin
        want = colors_due.pop_front();
        results_checked++;
        if (m_axis_tdata !== want.color) report_mismatch("new_color", want.color, m_axis_tdata);
        if (m_axis_tlast !== want.last)
          report_mismatch("last_of_frame", colu_pkg::ColorW'(want.last),
                          colu_pkg::ColorW'(m_axis_tlast));
      end
    end
  end

  function automatic int clip_size(input logic [colu_pkg::CfgW-1:0] raw, input int top);
    int v;
    v = int'(raw);
    if (v < SmallestSize) v = SmallestSize;
    if (v > top) v = top;
    return v;
  endfunction

  task automatic reset_predictor();
    width_setting  = colu_pkg::CfgW'(colu_pkg::ResetSize);
    height_setting = colu_pkg::CfgW'(colu_pkg::ResetSize);
    for (int i = 0; i < colu_pkg::MaxColumns; i++) begin
      row_above_above[i] = '0;
      row_above[i]       = '0;
    end
    for (int i = 0; i < 9; i++) neighborhood[i] = '0;
    next_col = 0;
    next_row = 0;
  endtask

  // Shifts one cell into the neighborhood and queues the next generation of
  // the interior cell one row and one column behind it.
  task automatic predict_next_color(input logic [colu_pkg::ColorW-1:0] incoming);
    int ncols, nrows, c, r, live;
    logic [colu_pkg::ColorW-1:0] from_top, from_mid;
    logic [colu_pkg::ColorW+1:0] color_sum;
    life_result_t                res;
    ncols = clip_size(width_setting, colu_pkg::MaxColumns);
    nrows = clip_size(height_setting, colu_pkg::MaxRows);
    c = (next_col >= ncols) ? 0 : next_col;
    r = (next_row >= nrows) ? 0 : next_row;
    from_top = row_above_above[c];
    from_mid = row_above[c];
    row_above_above[c] = from_mid;
    row_above[c]       = incoming;
    for (int k = 0; k < 3; k++) begin
      neighborhood[k*3]   = neighborhood[k*3+1];
      neighborhood[k*3+1] = neighborhood[k*3+2];
    end
    neighborhood[2] = from_top;
    neighborhood[5] = from_mid;
    neighborhood[8] = incoming;
    if (r >= 2 && c >= 2) begin
      live = 0;
      color_sum = '0;
      for (int k = 0; k < 9; k++) begin
        if (k != 4 && neighborhood[k] != '0) begin
          live++;
          color_sum += neighborhood[k];
        end
      end
      if (neighborhood[4] != '0)
        res.color = (live == SurviveLow || live == BirthNbrs) ? neighborhood[4] : '0;
      else if (live == BirthNbrs)
        // The packed word is averaged as one integer, carries between channels and all.
        res.color = colu_pkg::ColorW'(color_sum / BirthNbrs);
      else
        res.color = '0;
      res.last = (r == nrows - 1 && c == ncols - 1);
      colors_due.push_back(res);
    end
    c++;
    if (c >= ncols) begin
      c = 0;
      r++;
      if (r >= nrows) r = 0;
    end
    next_col = c;
    next_row = r;
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer
  // with tvalid still high, so back-to-back transfers need no extra edge.
  task automatic send_color(input logic [colu_pkg::ColorW-1:0] color);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= color;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    predict_next_color(color);
    cells_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [colu_pkg::ColorW-1:0] random_color(input int dead_pct);
    logic [colu_pkg::ColorW-1:0] v;
    if ($urandom_range(99) < dead_pct) return '0;
    case ($urandom_range(9))
      0:       v = '1;
      1:       v = colu_pkg::ColorW'(1);
      default: v = colu_pkg::ColorW'($urandom());
    endcase
    if (v == '0) v = colu_pkg::ColorW'(1);
    return v;
  endfunction

  task automatic send_colors(input int count, input int dead_pct);
    for (int i = 0; i < count; i++) send_color(random_color(dead_pct));
  endtask

  // Leaves the block idle: input stopped, every result in, pipeline empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (colors_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [colu_pkg::IdxW-1:0] idx,
                           input logic [colu_pkg::CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      colu_pkg::RegColumns: begin
        width_setting = value;
        next_col = 0;
        next_row = 0;
      end
      colu_pkg::RegRows: begin
        height_setting = value;
        next_col = 0;
        next_row = 0;
      end
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [colu_pkg::CfgW-1:0] ncols,
                           input logic [colu_pkg::CfgW-1:0] nrows);
    settle();
    if ($urandom_range(1)) begin
      write_reg(colu_pkg::RegColumns, ncols);
      write_reg(colu_pkg::RegRows, nrows);
    end else begin
      write_reg(colu_pkg::RegRows, nrows);
      write_reg(colu_pkg::RegColumns, ncols);
    end
    size_settings++;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // The 64 x 64 default applies before any write; two rows and a bit suffice.
  task automatic test_reset_size();
    send_colors(2 * colu_pkg::ResetSize + 10, 55);
  endtask

  // A 5 x 5 grid with a colored column: births that carry across channels,
  // survival with two and three neighbors, death by crowding, dead cells
  // left dead, and the frame end flag on the final interior cell.
  task automatic test_rule_cases();
    logic [colu_pkg::ColorW-1:0] grid [25] = '{
      24'h000000, 24'h000100, 24'h000200, 24'h000300, 24'h000000,
      24'h000000, 24'h000000, 24'hFFFFFF, 24'h000000, 24'h000000,
      24'h000000, 24'h000000, 24'h000001, 24'h000000, 24'h000000,
      24'h000000, 24'h000000, 24'h000002, 24'h000003, 24'h000000,
      24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000};
    configure(colu_pkg::CfgW'(5), colu_pkg::CfgW'(5));
    for (int i = 0; i < 25; i++) send_color(grid[i]);
  endtask

  // Written sizes beyond both ends, and the smallest grids. The oversized
  // width keeps the stream inside its first row, where no result may appear.
  task automatic test_size_extremes();
    configure('1, '0);
    send_colors(WideCells, 55);
    configure(colu_pkg::CfgW'(1), colu_pkg::CfgW'(colu_pkg::MaxRows + 1));
    send_colors(SmallestSize * TallRows, 55);
    configure(colu_pkg::CfgW'(2), colu_pkg::CfgW'(SmallestSize));
    send_colors(2 * SmallestSize * SmallestSize, 40);
    configure(colu_pkg::CfgW'(SmallestSize), colu_pkg::CfgW'(SmallestSize));
    send_colors(SmallestSize * SmallestSize, 0);
  endtask

  // A write to an index without a register, in the middle of a frame.
  task automatic test_spare_register();
    configure(colu_pkg::CfgW'(5), colu_pkg::CfgW'(4));
    send_colors(7, 50);
    settle();
    write_reg(RegSpareA, colu_pkg::CfgW'($urandom()));
    write_reg(RegSpareB, colu_pkg::CfgW'($urandom()));
    send_colors(13, 50);
  endtask

  // Mostly whole frames of random sizes and content; some frames are cut
  // short by a new size, and some streams simply run on across frames.
  task automatic test_random_frames(input int count);
    int sent, kind, ncols, nrows, dead_pct, area;
    logic [colu_pkg::CfgW-1:0] wcols, wrows;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(9);
      dead_pct = $urandom_range(15, 85);
      if (kind != 8) begin
        case ($urandom_range(19))
          0:       wcols = colu_pkg::CfgW'($urandom_range(0, 2));
          1, 2, 3: wcols = colu_pkg::CfgW'($urandom_range(13, 70));
          default: wcols = colu_pkg::CfgW'($urandom_range(3, 12));
        endcase
        wrows = ($urandom_range(19) == 0) ? colu_pkg::CfgW'($urandom_range(0, 2))
                                          : colu_pkg::CfgW'($urandom_range(3, 7));
        configure(wcols, wrows);
      end
      ncols = clip_size(width_setting, colu_pkg::MaxColumns);
      nrows = clip_size(height_setting, colu_pkg::MaxRows);
      area  = ncols * nrows;
      case (kind)
        7:       area = $urandom_range(1, area - 1);
        8:       area = $urandom_range(1, 2 * area);
        default: area = area * $urandom_range(1, 2);
      endcase
      send_colors(area, dead_pct);
      sent += area;
    end
  endtask

  initial begin
    reset_predictor();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_idling(35, 74);
    test_reset_size();
    test_rule_cases();
    test_size_extremes();
    test_spare_register();
    test_random_frames(RandomItems);
    set_idling(74, 35);
    test_random_frames(RandomItems);
    set_idling(0, 0);
    test_random_frames(RandomItems);
    settle();

    $display("Sent %0d cells under %0d grid sizes and checked %0d next-generation results.",
             cells_sent, size_settings, results_checked);
    $display("Sizes ran from the clamped minimum to clamped oversize writes, with %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
